>>> rtl/core/spc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Stepper position controller package
// Shared widths, field positions, command and register codes.
// ---------------------------------------------------------------------------
package spc_pkg;

    // Position word, 1/65536 degree units, two's complement
    localparam int POS_BITS = 32;

    // Configuration registers
    localparam int STEP_W     = 24;
    localparam int LIMIT_W    = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_ADDR_W = 2;

    localparam logic [STEP_W-1:0]  STEP_SIZE_RST   = 24'd117965;
    localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST = 31'd23592960;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_SIZE   = 2'd0,
        REG_UPPER_LIMIT = 2'd1,
        REG_HOME_DIR    = 2'd2
    } cfg_reg_t;

    // Input command codes, carried on s_tuser
    localparam int FUNC_W = 3;
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 3'd0,
        FUNC_HOME    = 3'd1,
        FUNC_MOVE    = 3'd2,
        FUNC_ENABLE  = 3'd3,
        FUNC_DISABLE = 3'd4
    } func_t;

    // Input tdata layout
    localparam int TARGET_W   = 32;
    localparam int IN_DATA_W  = 40;
    localparam int IN_TGT_LSB = 0;
    localparam int IN_LIMIT   = TARGET_W;

    // Output tdata layout
    localparam int OUT_POS_W   = 32;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_PULSE   = 0;
    localparam int OUT_DIR     = 1;
    localparam int OUT_ENN     = 2;
    localparam int OUT_POS_LSB = 3;
    localparam int OUT_BUSY    = OUT_POS_LSB + OUT_POS_W;
    localparam int OUT_DONE    = OUT_BUSY + 1;
    localparam int OUT_USED_W  = OUT_DONE + 1;

endpackage : spc_pkg
`default_nettype wire

>>> rtl/core/stepper_position_controller_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Stepper position controller core
// Step/direction controller with homing and position tracking.
// ---------------------------------------------------------------------------
// Each input transaction (tick or command) produces exactly one output
// transaction in the next cycle. The position update, step decision and mode
// change are done in a single registered pass: one step adder feeding the
// range compare and the after-step distance compare. A new transaction is
// taken every clock cycle while the output register is empty or being
// drained, so the sustained rate is one item per cycle. Configuration writes
// take effect at the next clock edge and must only be issued while idle.
module stepper_position_controller_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [spc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // tdata: target_position[31:0], limit_pressed[32], zero fill
    input  wire logic [spc_pkg::IN_DATA_W-1:0]    s_tdata,
    // tuser: func[2:0]
    input  wire logic [spc_pkg::FUNC_W-1:0]       s_tuser,
    // output stream
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // tdata: step_pulse[0], dir_level[1], enable_n[2], current_position[34:3],
    //        busy_res[35], home_done[36], zero fill
    output      logic [spc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import spc_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_HOMING,
        MODE_MOVE
    } mode_t;

    typedef logic signed [POS_BITS-1:0] pos_t;

    localparam int CMP_BITS  = ((POS_BITS > LIMIT_W) ? POS_BITS : LIMIT_W) + 1;
    localparam int DIST_BITS = ((POS_BITS + 1 > STEP_W) ? POS_BITS + 1 : STEP_W) + 1;

    // True when |a - b| exceeds the step size
    function automatic logic dist_exceeds(input pos_t a, input pos_t b,
                                          input logic [STEP_W-1:0] step);
        logic signed [DIST_BITS-1:0] d;
        logic signed [DIST_BITS-1:0] s;
        begin
            d = DIST_BITS'(a) - DIST_BITS'(b);
            s = DIST_BITS'({1'b0, step});
            return (d > s) || (d < -s);
        end
    endfunction

    // Configuration registers
    logic [STEP_W-1:0]  step_size_reg;
    logic [LIMIT_W-1:0] upper_limit_reg;
    logic               home_neg_reg;

    // Controller state
    mode_t mode_reg,   mode_next;
    pos_t  pos_reg,    pos_next;
    pos_t  goal_reg,   goal_next;
    logic  dir_reg,    dir_next;
    logic  dis_reg,    dis_next;

    // Output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Datapath signals
    logic         accept;
    func_t        func;
    pos_t         target;
    logic         limit_pressed;
    pos_t         step_ext;
    pos_t         pos_step;
    logic signed [CMP_BITS-1:0] step_cmp;
    logic         step_in_range;
    logic         far_now;
    logic         far_after;
    logic         far_target;
    logic         pulse;
    logic         done;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign func          = func_t'(s_tuser);
    assign target        = pos_t'($signed(s_tdata[IN_TGT_LSB +: TARGET_W]));
    assign limit_pressed = s_tdata[IN_LIMIT];

    // One step in the current direction and its checks
    assign step_ext      = pos_t'({1'b0, step_size_reg});
    assign pos_step      = dir_reg ? (pos_reg - step_ext) : (pos_reg + step_ext);
    assign step_cmp      = CMP_BITS'(pos_step);
    // Strictly positive and strictly below the upper limit
    assign step_in_range = !step_cmp[CMP_BITS-1] && (step_cmp != '0) &&
                           (step_cmp < $signed(CMP_BITS'({1'b0, upper_limit_reg})));
    assign far_now       = dist_exceeds(pos_reg, goal_reg, step_size_reg);
    assign far_after     = dist_exceeds(pos_step, goal_reg, step_size_reg);
    assign far_target    = dist_exceeds(pos_reg, target, step_size_reg);

    // Next state and result for the accepted transaction
    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        goal_next = goal_reg;
        dir_next  = dir_reg;
        dis_next  = dis_reg;
        pulse     = 1'b0;
        done      = 1'b0;
        case (func)
            FUNC_TICK: begin
                case (mode_reg)
                    MODE_HOMING: begin
                        if (limit_pressed) begin
                            pos_next  = '0;
                            mode_next = MODE_IDLE;
                            done      = 1'b1;
                        end else begin
                            pos_next = pos_step;
                            pulse    = step_in_range;
                        end
                    end
                    MODE_MOVE: begin
                        if (far_now) begin
                            pos_next = pos_step;
                            pulse    = step_in_range;
                        end
                        if (!(far_now && far_after)) begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    default: begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            FUNC_HOME: begin
                pos_next  = pos_t'({1'b0, upper_limit_reg});
                dir_next  = home_neg_reg;
                mode_next = MODE_HOMING;
            end
            FUNC_MOVE: begin
                if (target == pos_reg) begin
                    mode_next = MODE_IDLE;
                end else begin
                    goal_next = target;
                    dir_next  = (target < pos_reg);
                    mode_next = far_target ? MODE_MOVE : MODE_IDLE;
                end
            end
            FUNC_ENABLE: begin
                dis_next = 1'b0;
            end
            FUNC_DISABLE: begin
                dis_next = 1'b1;
            end
            default: begin
                dis_next = dis_reg;
            end
        endcase

        m_tdata_next                          = '0;
        m_tdata_next[OUT_PULSE]               = pulse;
        m_tdata_next[OUT_DIR]                 = dir_next;
        m_tdata_next[OUT_ENN]                 = dis_next;
        m_tdata_next[OUT_POS_LSB +: OUT_POS_W] = OUT_POS_W'(pos_next);
        m_tdata_next[OUT_BUSY]                = (mode_next != MODE_IDLE);
        m_tdata_next[OUT_DONE]                = done;
    end

    // Hold configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg   <= STEP_SIZE_RST;
            upper_limit_reg <= UPPER_LIMIT_RST;
            home_neg_reg    <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_STEP_SIZE:   step_size_reg   <= cfg_wdata[STEP_W-1:0];
                REG_UPPER_LIMIT: upper_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_HOME_DIR:    home_neg_reg    <= cfg_wdata[0];
                default:         home_neg_reg    <= home_neg_reg;
            endcase
        end
    end

    // Advance state and load the result on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            goal_reg     <= '0;
            dir_reg      <= 1'b0;
            dis_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg    <= mode_next;
                pos_reg     <= pos_next;
                goal_reg    <= goal_next;
                dir_reg     <= dir_next;
                dis_reg     <= dis_next;
                m_tdata_reg <= m_tdata_next;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule : stepper_position_controller_core
`default_nettype wire

>>> rtl/core/spc_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Stepper position controller checker
// Port-level assertions on the output register and result fields.
// ---------------------------------------------------------------------------
module spc_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [spc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import spc_pkg::*;

    // Output register empties only through a transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction dropped or changed while stalled");

    // A stalled full output register blocks the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output register full and stalled");

    // Every accepted transaction gives a result in the next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted transaction produced no result");

    // Homing completion zeroes the position, ends the operation, takes no step
    a_home_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_DONE] |->
            (m_tdata[OUT_POS_LSB +: OUT_POS_W] == '0) && !m_tdata[OUT_BUSY] &&
            !m_tdata[OUT_PULSE])
        else $error("home done with non-zero position, busy or pulse");

    // Nothing valid straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule : spc_checker

bind stepper_position_controller_core spc_checker u_spc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
